// ----- rtl/swk_pkg.sv -----
// Shared constants and types of the sliding-window rank filter.
package swk_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;

	// Fixed field widths of the register and the rank query
	localparam int CFG_W  = 7;
	localparam int RANK_W = 7;

	localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = CFG_W'(1);

	// Per-cycle commands broadcast to every cell of the sorted row
	typedef struct packed {
		logic clr;   // drop every stored sample
		logic ins;   // insert the new sample in order
		logic rmv;   // close the gap at and after the masked cell
	} cell_ctl_t;

endpackage

// ----- rtl/swk_sample_if.sv -----
// Sample channel: one sample with its rank query per item.
interface swk_sample_if #(
	parameter int SAMPLE_BITS = swk_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [swk_pkg::RANK_W-1:0]    rank;

	modport source (output valid, output sample, output rank, input ready);
	modport sink   (input valid, input sample, input rank, output ready);
endinterface

// ----- rtl/swk_result_if.sv -----
// Result channel: the ranked sample and its invalid-rank flag per item.
interface swk_result_if #(
	parameter int SAMPLE_BITS = swk_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] kth_value;
	logic                          rank_invalid;

	modport source (output valid, output kth_value, output rank_invalid, input ready);
	modport sink   (input valid, input kth_value, input rank_invalid, output ready);
endinterface

// ----- rtl/swk_cfg_if.sv -----
// Configuration write channel carrying the window size.
interface swk_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [swk_pkg::CFG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/swk_cell.sv -----
// One cell of the sorted row: holds a sample, its age and an occupied flag.
module swk_cell #(
	parameter int SAMPLE_BITS = swk_pkg::SAMPLE_BITS_DEF,
	parameter int AGE_W       = 6,
	parameter int IDX_W       = 7,
	parameter int IDX         = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swk_pkg::cell_ctl_t            ctl,
	input  logic signed [SAMPLE_BITS-1:0] new_val,
	input  logic signed [SAMPLE_BITS-1:0] left_val,
	input  logic [AGE_W-1:0]              left_age,
	input  logic                          left_occ,
	input  logic                          left_gt,
	input  logic signed [SAMPLE_BITS-1:0] right_val,
	input  logic [AGE_W-1:0]              right_age,
	input  logic                          right_occ,
	input  logic                          rm_mask,
	input  logic [IDX_W-1:0]              rank_m1,
	input  logic [AGE_W-1:0]              oldest_age,
	output logic signed [SAMPLE_BITS-1:0] val,
	output logic [AGE_W-1:0]              age,
	output logic                          occ,
	output logic                          gt,
	output logic                          old_hit,
	output logic [SAMPLE_BITS-1:0]        pick
);

	logic signed [SAMPLE_BITS-1:0] val_q;
	logic [AGE_W-1:0]              age_q;
	logic                          occ_q;
	logic                          from_left;
	logic                          take_new;
	logic                          shift_in;

	assign gt        = occ_q && (val_q > new_val);
	assign from_left = left_occ && left_gt;
	assign take_new  = !from_left && (gt || (!occ_q && left_occ));
	assign shift_in  = ctl.rmv && rm_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.clr) begin
			occ_q <= 1'b0;
		end else if (ctl.ins) begin
			if (from_left || take_new) begin
				occ_q <= 1'b1;
			end
		end else if (shift_in) begin
			occ_q <= right_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (from_left) begin
				val_q <= left_val;
				age_q <= left_age + AGE_W'(1);
			end else if (take_new) begin
				val_q <= new_val;
				age_q <= '0;
			end else if (occ_q) begin
				age_q <= age_q + AGE_W'(1);
			end
		end else if (shift_in) begin
			val_q <= right_val;
			age_q <= right_age;
		end
	end

	assign val     = val_q;
	assign age     = age_q;
	assign occ     = occ_q;
	assign old_hit = occ_q && (age_q == oldest_age);
	assign pick    = (rank_m1 == IDX_W'(IDX)) ? val_q : '0;

endmodule

// ----- rtl/sliding_window_kth_smallest_top.sv -----
// Top level of the sliding-window rank filter: control and the row of sorted cells.
//
// Use: samples arrive on sample_ch, each with a 1-based rank query. The block
// keeps the most recent window_size samples in a row of cells sorted in
// ascending order, each cell also tracking the age of its sample. Until the
// window is full an item is only stored and gives no result; after that each
// item returns on result_ch the sample at the queried rank (1 = smallest),
// or 0 with rank_invalid set when the rank is 0 or above the window size.
// The oldest sample then leaves the window.
// Timing: the sorted insert happens in the cycle the item is accepted, then
// the rank select and oldest-sample search run in the select state, and for
// a producing item the removal and output load in the remove state. A new
// item is accepted only back in idle, as the steps share the one cell row.
// Stall: a finished result waits in the output register; the next item is
// still accepted and only its removal step holds while that register is full.
// Reset: arst_n empties the window, sets the window size to 1 and clears the
// output valid flag. A write on cfg sets the window size (0 acts as 1, values
// above the cell count saturate) and empties the window; write it only idle.
module sliding_window_kth_smallest_top #(
	parameter int WINDOW_MAX  = swk_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swk_pkg::SAMPLE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	swk_sample_if.sink    sample_ch,
	swk_result_if.source  result_ch,
	swk_cfg_if.sink       cfg
);

	localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W = (CNT_W > swk_pkg::CFG_W) ? CNT_W : swk_pkg::CFG_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEL  = 2'd1;
	localparam logic [1:0] ST_RMV  = 2'd2;

	logic [1:0]                  state_q;
	logic [swk_pkg::CFG_W-1:0]   win_q;
	logic [CNT_W-1:0]            fill_q;
	logic [swk_pkg::RANK_W-1:0]  rank_q;
	logic [SAMPLE_BITS-1:0]      kth_q;
	logic                        inval_q;
	logic [WINDOW_MAX-1:0]       rm_oh_q;
	logic                        out_vld_q;
	logic [SAMPLE_BITS-1:0]      out_kth_q;
	logic                        out_inv_q;

	logic [CMP_W-1:0]            win_ext;
	logic [CMP_W-1:0]            eff;
	logic [CMP_W-1:0]            rank_ext;
	logic [CMP_W-1:0]            rank_m1;
	logic [AGE_W-1:0]            oldest_age;
	logic                        rank_bad;
	logic                        accept;
	logic                        out_free;
	logic                        window_full;
	logic [WINDOW_MAX-1:0]       rm_mask;
	logic [WINDOW_MAX-1:0]       old_hit;
	logic [WINDOW_MAX-1:0]       cell_occ;
	logic [WINDOW_MAX-1:0]       cell_gt;
	logic [SAMPLE_BITS-1:0]      pick_or;
	swk_pkg::cell_ctl_t          ctl;

	logic signed [SAMPLE_BITS-1:0] cell_val  [WINDOW_MAX];
	logic [AGE_W-1:0]              cell_age  [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0]        cell_pick [WINDOW_MAX];

	// Effective window size: zero acts as one, saturate at the cell count
	assign win_ext = CMP_W'(win_q);
	always_comb begin
		if (win_q == '0) begin
			eff = CMP_W'(1);
		end else if (win_ext > CMP_W'(WINDOW_MAX)) begin
			eff = CMP_W'(WINDOW_MAX);
		end else begin
			eff = win_ext;
		end
	end

	assign oldest_age  = AGE_W'(eff - CMP_W'(1));
	assign rank_ext    = CMP_W'(rank_q);
	assign rank_m1     = rank_ext - CMP_W'(1);
	assign rank_bad    = (rank_q == '0) || (rank_ext > eff);
	assign window_full = !(CMP_W'(fill_q) < (eff - CMP_W'(1)));

	assign accept   = sample_ch.valid && sample_ch.ready;
	assign out_free = !out_vld_q || result_ch.ready;

	// Remove the oldest cell: it and every cell after it take the right neighbor
	assign rm_mask = ~(rm_oh_q - WINDOW_MAX'(1));

	assign ctl.clr = cfg.valid && cfg.ready;
	assign ctl.ins = accept;
	assign ctl.rmv = (state_q == ST_RMV) && out_free;

	// Row of sorted cells; cell 0 sees an occupied, not-greater left edge
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] l_val;
		logic [AGE_W-1:0]              l_age;
		logic                          l_occ;
		logic                          l_gt;
		logic signed [SAMPLE_BITS-1:0] r_val;
		logic [AGE_W-1:0]              r_age;
		logic                          r_occ;

		if (i == 0) begin : g_left_edge
			assign l_val = '0;
			assign l_age = '0;
			assign l_occ = 1'b1;
			assign l_gt  = 1'b0;
		end else begin : g_left
			assign l_val = cell_val[i-1];
			assign l_age = cell_age[i-1];
			assign l_occ = cell_occ[i-1];
			assign l_gt  = cell_gt[i-1];
		end

		if (i == WINDOW_MAX - 1) begin : g_right_edge
			assign r_val = '0;
			assign r_age = '0;
			assign r_occ = 1'b0;
		end else begin : g_right
			assign r_val = cell_val[i+1];
			assign r_age = cell_age[i+1];
			assign r_occ = cell_occ[i+1];
		end

		swk_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.AGE_W       (AGE_W),
			.IDX_W       (CMP_W),
			.IDX         (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_val    (sample_ch.sample),
			.left_val   (l_val),
			.left_age   (l_age),
			.left_occ   (l_occ),
			.left_gt    (l_gt),
			.right_val  (r_val),
			.right_age  (r_age),
			.right_occ  (r_occ),
			.rm_mask    (rm_mask[i]),
			.rank_m1    (rank_m1),
			.oldest_age (oldest_age),
			.val        (cell_val[i]),
			.age        (cell_age[i]),
			.occ        (cell_occ[i]),
			.gt         (cell_gt[i]),
			.old_hit    (old_hit[i]),
			.pick       (cell_pick[i])
		);
	end

	// At most one cell drives a nonzero pick, so OR them together
	always_comb begin
		pick_or = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			pick_or = pick_or | cell_pick[i];
		end
	end

	// Control: insert on accept, select and find oldest, then remove and emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			win_q     <= swk_pkg::WINDOW_SIZE_RST;
			fill_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// Load a new result on removal, else drop the one just taken
			if (ctl.rmv) begin
				out_vld_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				win_q  <= cfg.data;
				fill_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (window_full) begin
						state_q <= ST_RMV;
					end else begin
						fill_q  <= fill_q + CNT_W'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_RMV: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: hold the query, the selected sample and the result
	always_ff @(posedge clk) begin
		if (accept) begin
			rank_q <= sample_ch.rank;
		end
		if (state_q == ST_SEL) begin
			kth_q   <= rank_bad ? '0 : pick_or;
			inval_q <= rank_bad;
			rm_oh_q <= old_hit;
		end
		if (ctl.rmv) begin
			out_kth_q <= kth_q;
			out_inv_q <= inval_q;
		end
	end

	assign sample_ch.ready        = (state_q == ST_IDLE);
	assign cfg.ready              = 1'b1;
	assign result_ch.valid        = out_vld_q;
	assign result_ch.kth_value    = out_kth_q;
	assign result_ch.rank_invalid = out_inv_q;

`ifndef SYNTHESIS
	// Exactly one cell holds the oldest sample when the window is full
	a_one_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RMV) |-> $onehot(rm_oh_q))
		else $error("oldest sample not unique");

	// Stored samples never reach a full window between items
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(fill_q) < eff)
		else $error("fill count reached the window size");

	// Occupied cells match the fill count while idle
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ($countones(cell_occ) == int'(fill_q)))
		else $error("cell occupancy disagrees with fill count");

	// A result appears only out of the removal step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> ($past(state_q) == ST_RMV))
		else $error("result without removal step");

	// Invalid rank always returns zero
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_inv_q) |-> (out_kth_q == '0))
		else $error("invalid rank with nonzero value");
`endif

endmodule
